>>> hdl/smlfq_pkg.sv
// types, constants and request codes for the stride / mlfq scheduler
// no dependencies

package smlfq_pkg;

    localparam int ENTRIES  = 64;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int PASS_W   = 32;
    localparam int TKT_W    = 7;
    localparam int LVL_W    = 2;
    localparam int TICK_W   = 5;
    localparam int BOOST_W  = 8;
    localparam int CFG_W    = 8;
    localparam int CIDX_W   = 3;

    localparam logic [TKT_W-1:0] SHARE_WHOLE = 7'd100;
    localparam logic [TKT_W-1:0] LIMIT_MAX   = 7'd99;

    localparam logic [2:0] OP_PICK    = 3'd0;
    localparam logic [2:0] OP_TICK    = 3'd1;
    localparam logic [2:0] OP_GRANT   = 3'd2;
    localparam logic [2:0] OP_RELEASE = 3'd3;
    localparam logic [2:0] OP_READY   = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_LIMIT   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_QTOP    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_QMID    = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_QBOT    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_BOOST   = 3'd4;

    typedef struct packed {
        logic [TKT_W-1:0]  tickets;
        logic [PASS_W-1:0] pass;
        logic [LVL_W-1:0]  level;
        logic [TICK_W-1:0] ticks;
    } rec_t;

endpackage

>>> hdl/stride_mlfq_scheduler.sv
// stride scheduler with mlfq side: entry table, sequencer and shared divider
// depends on smlfq_pkg
// a pick divides to advance the chosen side's pass, then scans all 64 entries; with no tickets
// it skips the division, and a stride hit takes a second division for the entry's pass
// (7-step divisions); a tick may add a boost sweep over all entries; unused codes go
// straight to the finish; one request at a time, the next is taken in the done cycle, no stall
// async active-low reset clears the table through per-entry valid bits, no clearing pass

module stride_mlfq_scheduler
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    op,
    input  logic [smlfq_pkg::IDX_W-1:0]   entry,
    input  logic [smlfq_pkg::TKT_W-1:0]   share,
    input  logic                          ready_req,
    output logic                          done,
    output logic [smlfq_pkg::IDX_W-1:0]   chosen,
    output logic                          chosen_valid,
    output logic                          from_stride,
    output logic                          status,
    output logic [smlfq_pkg::TKT_W-1:0]   granted,
    input  logic                          cfg_we,
    input  logic [smlfq_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [smlfq_pkg::CFG_W-1:0]   cfg_data
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DIV     = 4'd1;
    localparam logic [3:0] S_SIDE    = 4'd2;
    localparam logic [3:0] S_SCAN_RD = 4'd3;
    localparam logic [3:0] S_SCAN_EV = 4'd4;
    localparam logic [3:0] S_PASS_WB = 4'd5;
    localparam logic [3:0] S_ONE_RD  = 4'd6;
    localparam logic [3:0] S_ONE_EV  = 4'd7;
    localparam logic [3:0] S_SWP_RD  = 4'd8;
    localparam logic [3:0] S_SWP_EV  = 4'd9;
    localparam logic [3:0] S_FIN     = 4'd10;

    localparam int IW = smlfq_pkg::IDX_W;
    localparam int TW = smlfq_pkg::TKT_W;
    localparam int PW = smlfq_pkg::PASS_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(smlfq_pkg::ENTRIES - 1);
    localparam logic [2:0] DIV_LAST = 3'(TW - 1);

    logic [3:0]                state_reg, state_next;
    logic [2:0]                op_reg, op_next;
    logic [TW-1:0]             share_reg, share_next;
    logic                      rdy_reg, rdy_next;
    logic [IW-1:0]             addr_reg, addr_next;
    logic [IW-1:0]             cnt_reg, cnt_next;
    logic [IW-1:0]             best_idx_reg, best_idx_next;
    logic                      best_found_reg, best_found_next;
    smlfq_pkg::rec_t           best_rec_reg, best_rec_next;
    logic [2:0]                best_level_reg, best_level_next;
    logic                      side_reg, side_next;
    logic [TW-1:0]             div_rem_reg, div_rem_next;
    logic [TW-1:0]             div_quo_reg, div_quo_next;
    logic [TW-1:0]             div_den_reg, div_den_next;
    logic [2:0]                div_cnt_reg, div_cnt_next;
    logic                      div_ret_reg, div_ret_next;
    logic [TW-1:0]             total_reg, total_next;
    logic [7:0]                boost_cnt_reg, boost_cnt_next;
    logic [PW-1:0]             spass_reg, spass_next;
    logic [PW-1:0]             mpass_reg, mpass_next;
    logic [IW-1:0]             rp_reg, rp_next;
    logic [TW-1:0]             limit_reg;
    logic [4:0]                qtop_reg, qmid_reg, qbot_reg;
    logic [7:0]                bperiod_reg;
    logic                      done_reg, done_next;
    logic [IW-1:0]             chosen_reg, chosen_next;
    logic                      cvalid_reg, cvalid_next;
    logic                      fstride_reg, fstride_next;
    logic                      status_reg, status_next;
    logic [TW-1:0]             granted_reg, granted_next;
    logic [smlfq_pkg::ENTRIES-1:0] ready_reg, ready_next;
    logic [smlfq_pkg::ENTRIES-1:0] valid_reg, valid_next;

    smlfq_pkg::rec_t           mem [smlfq_pkg::ENTRIES];
    smlfq_pkg::rec_t           mem_q;
    logic                      valid_q;
    logic                      mem_we;
    logic [IW-1:0]             mem_waddr;
    smlfq_pkg::rec_t           mem_wdata;

    smlfq_pkg::rec_t           rec;
    smlfq_pkg::rec_t           nrec;
    logic [TW:0]               div_sh;
    logic [TW-1:0]             limit_eff;
    logic [TW-1:0]             rest;
    logic [TW:0]               sum;
    logic [smlfq_pkg::TICK_W-1:0] tk;
    logic [7:0]                bc;
    logic                      f_found;
    logic [IW-1:0]             f_idx;
    smlfq_pkg::rec_t           f_rec;
    logic [2:0]                f_level;
    logic                      elig;

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign chosen       = chosen_reg;
    assign chosen_valid = cvalid_reg;
    assign from_stride  = fstride_reg;
    assign status       = status_reg;
    assign granted      = granted_reg;

    assign rec       = valid_q ? mem_q : '0;
    assign limit_eff = (limit_reg > smlfq_pkg::LIMIT_MAX) ? smlfq_pkg::LIMIT_MAX : limit_reg;
    assign div_sh    = {div_rem_reg, div_quo_reg[TW-1]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_q <= 1'b0;
        end
        else
        begin
            valid_q <= valid_reg[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= 7'd80;
            qtop_reg    <= 5'd5;
            qmid_reg    <= 5'd10;
            qbot_reg    <= 5'd20;
            bperiod_reg <= 8'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                smlfq_pkg::CFG_LIMIT: limit_reg   <= cfg_data[TW-1:0];
                smlfq_pkg::CFG_QTOP:  qtop_reg    <= cfg_data[4:0];
                smlfq_pkg::CFG_QMID:  qmid_reg    <= cfg_data[4:0];
                smlfq_pkg::CFG_QBOT:  qbot_reg    <= cfg_data[4:0];
                smlfq_pkg::CFG_BOOST: bperiod_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        share_next      = share_reg;
        rdy_next        = rdy_reg;
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;
        best_idx_next   = best_idx_reg;
        best_found_next = best_found_reg;
        best_rec_next   = best_rec_reg;
        best_level_next = best_level_reg;
        side_next       = side_reg;
        div_rem_next    = div_rem_reg;
        div_quo_next    = div_quo_reg;
        div_den_next    = div_den_reg;
        div_cnt_next    = div_cnt_reg;
        div_ret_next    = div_ret_reg;
        total_next      = total_reg;
        boost_cnt_next  = boost_cnt_reg;
        spass_next      = spass_reg;
        mpass_next      = mpass_reg;
        rp_next         = rp_reg;
        done_next       = 1'b0;
        chosen_next     = chosen_reg;
        cvalid_next     = cvalid_reg;
        fstride_next    = fstride_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        ready_next      = ready_reg;
        valid_next      = valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = rec;
        nrec            = rec;
        rest            = total_reg - rec.tickets;
        sum             = {1'b0, rest} + {1'b0, share_reg};
        tk              = rec.ticks + 5'd1;
        bc              = boost_cnt_reg + 8'd1;
        f_found         = best_found_reg;
        f_idx           = best_idx_reg;
        f_rec           = best_rec_reg;
        f_level         = best_level_reg;
        elig            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = op;
                    share_next   = share;
                    rdy_next     = ready_req;
                    addr_next    = entry;
                    chosen_next  = '0;
                    cvalid_next  = 1'b0;
                    fstride_next = 1'b0;
                    status_next  = 1'b0;
                    granted_next = '0;
                    case (op)
                        smlfq_pkg::OP_PICK:
                        begin
                            div_cnt_next = '0;
                            div_rem_next = '0;
                            div_quo_next = smlfq_pkg::SHARE_WHOLE;
                            div_ret_next = 1'b0;
                            if (total_reg != '0)
                            begin
                                side_next    = (spass_reg <= mpass_reg);
                                div_den_next = (spass_reg <= mpass_reg) ? total_reg
                                             : smlfq_pkg::SHARE_WHOLE - total_reg;
                                state_next   = S_DIV;
                            end
                            else
                            begin
                                side_next  = 1'b0;
                                state_next = S_SIDE;
                            end
                        end
                        smlfq_pkg::OP_TICK, smlfq_pkg::OP_GRANT,
                        smlfq_pkg::OP_RELEASE, smlfq_pkg::OP_READY:
                        begin
                            state_next = S_ONE_RD;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_DIV:
            begin
                if (div_sh >= {1'b0, div_den_reg})
                begin
                    div_rem_next = TW'(div_sh - {1'b0, div_den_reg});
                    div_quo_next = {div_quo_reg[TW-2:0], 1'b1};
                end
                else
                begin
                    div_rem_next = div_sh[TW-1:0];
                    div_quo_next = {div_quo_reg[TW-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 3'd1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = div_ret_reg ? S_PASS_WB : S_SIDE;
                end
            end

            S_SIDE:
            begin
                if (total_reg != '0)
                begin
                    if (side_reg)
                    begin
                        spass_next = spass_reg + PW'(div_quo_reg);
                    end
                    else
                    begin
                        mpass_next = mpass_reg + PW'(div_quo_reg);
                    end
                end
                addr_next       = side_reg ? '0 : rp_reg;
                cnt_next        = '0;
                best_found_next = 1'b0;
                best_level_next = 3'd4;
                state_next      = S_SCAN_RD;
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_EV;
            end

            S_SCAN_EV:
            begin
                if (side_reg)
                begin
                    elig = ready_reg[addr_reg] && rec.tickets != '0
                        && (!best_found_reg || rec.pass < best_rec_reg.pass);
                end
                else
                begin
                    elig = ready_reg[addr_reg] && rec.tickets == '0
                        && {1'b0, rec.level} < best_level_reg;
                end
                if (elig)
                begin
                    f_found = 1'b1;
                    f_idx   = addr_reg;
                    f_rec   = rec;
                    f_level = {1'b0, rec.level};
                end
                best_found_next = f_found;
                best_idx_next   = f_idx;
                best_rec_next   = f_rec;
                best_level_next = f_level;
                if (cnt_reg == LAST_IDX)
                begin
                    fstride_next = side_reg;
                    if (!f_found)
                    begin
                        state_next = S_FIN;
                    end
                    else if (side_reg)
                    begin
                        div_cnt_next = '0;
                        div_rem_next = '0;
                        div_quo_next = total_reg;
                        div_den_next = f_rec.tickets;
                        div_ret_next = 1'b1;
                        state_next   = S_DIV;
                    end
                    else
                    begin
                        rp_next     = (f_idx == LAST_IDX) ? '0 : f_idx + IW'(1);
                        chosen_next = f_idx;
                        cvalid_next = 1'b1;
                        state_next  = S_FIN;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + IW'(1);
                    addr_next  = (addr_reg == LAST_IDX) ? '0 : addr_reg + IW'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_PASS_WB:
            begin
                nrec        = best_rec_reg;
                nrec.pass   = best_rec_reg.pass + PW'(div_quo_reg);
                mem_we      = 1'b1;
                mem_waddr   = best_idx_reg;
                mem_wdata   = nrec;
                valid_next[best_idx_reg] = 1'b1;
                chosen_next = best_idx_reg;
                cvalid_next = 1'b1;
                state_next  = S_FIN;
            end

            S_ONE_RD:
            begin
                state_next = S_ONE_EV;
            end

            S_ONE_EV:
            begin
                state_next = S_FIN;
                case (op_reg)
                    smlfq_pkg::OP_TICK:
                    begin
                        nrec.ticks = tk;
                        case (rec.level)
                            2'd0:
                            begin
                                if (tk >= qtop_reg)
                                begin
                                    nrec.level = 2'd1;
                                    nrec.ticks = '0;
                                end
                            end
                            2'd1:
                            begin
                                if (tk >= qmid_reg)
                                begin
                                    nrec.level = 2'd2;
                                    nrec.ticks = '0;
                                end
                            end
                            2'd2:
                            begin
                                if (tk >= qbot_reg)
                                begin
                                    nrec.ticks = '0;
                                end
                            end
                            default: ;
                        endcase
                        mem_we    = 1'b1;
                        mem_wdata = nrec;
                        valid_next[addr_reg] = 1'b1;
                        if (bc >= bperiod_reg)
                        begin
                            boost_cnt_next = '0;
                            addr_next      = '0;
                            cnt_next       = '0;
                            state_next     = S_SWP_RD;
                        end
                        else
                        begin
                            boost_cnt_next = bc;
                        end
                    end
                    smlfq_pkg::OP_GRANT:
                    begin
                        if (share_reg == '0 || sum > {1'b0, limit_eff})
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            nrec.tickets = share_reg;
                            nrec.pass    = '0;
                            mem_we       = 1'b1;
                            mem_wdata    = nrec;
                            valid_next[addr_reg] = 1'b1;
                            total_next   = sum[TW-1:0];
                            granted_next = share_reg;
                        end
                    end
                    smlfq_pkg::OP_RELEASE:
                    begin
                        if (rec.tickets != '0)
                        begin
                            nrec.tickets = '0;
                            nrec.pass    = '0;
                            mem_we       = 1'b1;
                            mem_wdata    = nrec;
                            valid_next[addr_reg] = 1'b1;
                            total_next   = rest;
                        end
                    end
                    smlfq_pkg::OP_READY:
                    begin
                        if (rdy_reg && !ready_reg[addr_reg])
                        begin
                            nrec.level = '0;
                            nrec.ticks = '0;
                            mem_we     = 1'b1;
                            mem_wdata  = nrec;
                            valid_next[addr_reg] = 1'b1;
                        end
                        ready_next[addr_reg] = rdy_reg;
                    end
                    default: ;
                endcase
            end

            S_SWP_RD:
            begin
                state_next = S_SWP_EV;
            end

            S_SWP_EV:
            begin
                nrec.level = '0;
                nrec.ticks = '0;
                mem_we     = 1'b1;
                mem_wdata  = nrec;
                valid_next[addr_reg] = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next   = cnt_reg + IW'(1);
                    addr_next  = addr_reg + IW'(1);
                    state_next = S_SWP_RD;
                end
            end

            S_FIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_reg      <= '0;
            boost_cnt_reg  <= '0;
            spass_reg      <= '0;
            mpass_reg      <= '0;
            rp_reg         <= '0;
            done_reg       <= 1'b0;
            ready_reg      <= '0;
            valid_reg      <= '0;
            addr_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            boost_cnt_reg  <= boost_cnt_next;
            spass_reg      <= spass_next;
            mpass_reg      <= mpass_next;
            rp_reg         <= rp_next;
            done_reg       <= done_next;
            ready_reg      <= ready_next;
            valid_reg      <= valid_next;
            addr_reg       <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        share_reg      <= share_next;
        rdy_reg        <= rdy_next;
        cnt_reg        <= cnt_next;
        best_idx_reg   <= best_idx_next;
        best_found_reg <= best_found_next;
        best_rec_reg   <= best_rec_next;
        best_level_reg <= best_level_next;
        side_reg       <= side_next;
        div_rem_reg    <= div_rem_next;
        div_quo_reg    <= div_quo_next;
        div_den_reg    <= div_den_next;
        div_cnt_reg    <= div_cnt_next;
        div_ret_reg    <= div_ret_next;
        chosen_reg     <= chosen_next;
        cvalid_reg     <= cvalid_next;
        fstride_reg    <= fstride_next;
        status_reg     <= status_next;
        granted_reg    <= granted_next;
    end

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("done outside idle");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start");
    a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= smlfq_pkg::LIMIT_MAX)
        else $error("ticket total above cap");
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && granted_reg != '0) |-> !status_reg && !cvalid_reg)
        else $error("grant result inconsistent");
    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held longer than a cycle");
`endif

endmodule
